>>> hw/rtl/sdi_pkg.sv
// Shared types, constants and codes for the speed-to-drive interpolator.
`default_nettype none
package sdi_pkg;

  localparam int TABLE_DEPTH    = 16;
  localparam int DRIVE_MAX_CODE = 1023;
  localparam int STEP_SPACING   = 10;

  localparam int DRIVE_W = 10;
  localparam int STEPS_W = 5;
  localparam int SPEED_W = 32;
  localparam int FRAC_W  = 16;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int EIDX_W  = 4;

  localparam int POINT_MAX = STEP_SPACING * (TABLE_DEPTH - 1);
  localparam int POINT_W   = $clog2(POINT_MAX + 1);

  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 48;

  localparam logic [MUL_B_W-1:0] MPH_RATIO = 16'h9EF9;
  localparam logic [MUL_B_W-1:0] TENTH_FP  = 16'd6553;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_MPH_MODE   = 2'd0,
    REG_STEP_COUNT = 2'd1,
    REG_MAX_DRIVE  = 2'd2,
    REG_LOW_DRIVE  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE   = 1'b0,
    OP_TABLE_WR = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MPH_LO,
    ST_MPH_HI,
    ST_MPH_SUM,
    ST_SCAN,
    ST_RD_I,
    ST_RD_IM1,
    ST_DIFF,
    ST_A_LATCH,
    ST_B_MUL,
    ST_B_SUB,
    ST_S_LO,
    ST_S_HI,
    ST_ROUND,
    ST_RD_LAST,
    ST_CLAMP
  } sdi_state_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0]        b;
  } sdi_mul_op_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic [DRIVE_W-1:0] data;
  } sdi_tbl_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/speed_to_drive_interpolator.sv
// Top level of the speed-to-drive interpolator: register port, sequencer and datapath.
//
// A speed sample is converted to a drive code by a small sequencer around one shared
// 25x16 multiplier and a calibration table with one write port and one registered read
// port. A sample passes through an mph conversion when mph mode is set, a scan down the
// table points and the table reads, and, when it falls between two points, a chain of
// multiplies through the shared multiplier; one below the lowest point takes the low
// drive. A new item is accepted only while the sequencer is idle, and a table write
// item leaves it idle. The finished drive waits in an output register, and the next
// item is accepted meanwhile; a later sample holds in its last step until that register
// is free. The calibration table has no reset and must be written before samples that
// reach its entries.
`default_nettype none
module speed_to_drive_interpolator
  import sdi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input item: tvalid/tready handshake.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // speed_fixed [31:0], entry_index [35:32], entry_value [45:36], zero fill [47:46]
  input  wire logic [47:0]           in_tdata,
  // opcode [0]
  input  wire logic                  in_tuser,
  // Result item.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // drive [9:0], zero fill [15:10]
  output logic [15:0]                out_tdata,
  // kick [0]
  output logic                       out_tuser,
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic               mph_r;
  logic [STEPS_W-1:0] steps_r;
  logic [DRIVE_W-1:0] maxd_r;
  logic [DRIVE_W-1:0] lowd_r;
  logic               cfg_wr;
  cfg_reg_t           cfg_sel;

  sdi_state_t state_r, state_nxt;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic               eq_r, eq_nxt;
  logic [SPEED_W-1:0] spd_r, spd_nxt;
  logic [DRIVE_W-1:0] ei_r, ei_nxt;
  logic signed [MUL_A_W-1:0] a_r, a_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic [DRIVE_W-1:0] drv_r, drv_nxt;
  logic [DRIVE_W-1:0] last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DRIVE_W-1:0] out_drive_r, out_drive_nxt;
  logic               out_kick_r, out_kick_nxt;

  logic               in_acc;
  opcode_t            in_op;
  logic [STEPS_W-1:0] n_clamp;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   idx_i;
  logic [POINT_W-1:0] point;
  logic [FRAC_W-1:0]  sint;
  logic signed [DRIVE_W:0]   diff;
  logic signed [ACC_W-1:0]   prod_x;
  logic signed [ACC_W-1:0]   q;
  logic [DRIVE_W-1:0] clamped;

  sdi_mul_op_t        mul_op;
  logic signed [PROD_W-1:0] prod;
  sdi_tbl_wr_t        tbl_wr;
  logic [IDX_W-1:0]   raddr;
  logic [DRIVE_W-1:0] rdata;

  sdi_mul u_mul (
    .clk  (clk),
    .op   (mul_op),
    .prod (prod)
  );

  sdi_table u_table (
    .clk   (clk),
    .wr    (tbl_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mph_r   <= 1'b0;
      steps_r <= STEPS_W'(2);
      maxd_r  <= DRIVE_W'(DRIVE_MAX_CODE);
      lowd_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_MPH_MODE:   mph_r   <= cfg_pwdata[0];
        REG_STEP_COUNT: steps_r <= cfg_pwdata[STEPS_W-1:0];
        REG_MAX_DRIVE:  maxd_r  <= cfg_pwdata[DRIVE_W-1:0];
        REG_LOW_DRIVE:  lowd_r  <= cfg_pwdata[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_MPH_MODE:   cfg_prdata = CFG_DATA_W'(mph_r);
      REG_STEP_COUNT: cfg_prdata = CFG_DATA_W'(steps_r);
      REG_MAX_DRIVE:  cfg_prdata = CFG_DATA_W'(maxd_r);
      REG_LOW_DRIVE:  cfg_prdata = CFG_DATA_W'(lowd_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Input side and table writes.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_op     = opcode_t'(in_tuser);

  always_comb begin
    tbl_wr.we   = in_acc && (in_op == OP_TABLE_WR) &&
                  ({1'b0, in_tdata[35:32]} < (EIDX_W + 1)'(TABLE_DEPTH));
    tbl_wr.addr = IDX_W'(in_tdata[35:32]);
    tbl_wr.data = in_tdata[45:36];
  end

  // Lookup addressing.
  always_comb begin
    n_clamp = steps_r;
    if (steps_r < STEPS_W'(2)) begin
      n_clamp = STEPS_W'(2);
    end else if (steps_r > STEPS_W'(TABLE_DEPTH)) begin
      n_clamp = STEPS_W'(TABLE_DEPTH);
    end
  end

  assign last_idx = IDX_W'(n_clamp - STEPS_W'(1));
  assign idx_i    = IDX_W'(n_clamp) - k_r;
  assign point    = POINT_W'(k_r * STEP_SPACING);
  assign sint     = spd_r[SPEED_W-1:FRAC_W];
  assign diff     = $signed({1'b0, rdata}) - $signed({1'b0, ei_r});
  assign prod_x   = ACC_W'(prod);
  assign q        = acc_r >>> FRAC_W;

  always_comb begin
    if (q < 0) begin
      clamped = '0;
    end else if (q > ACC_W'(DRIVE_MAX_CODE)) begin
      clamped = DRIVE_W'(DRIVE_MAX_CODE);
    end else begin
      clamped = q[DRIVE_W-1:0];
    end
  end

  // Sequencer: next state, datapath and unit controls.
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    eq_nxt        = eq_r;
    spd_nxt       = spd_r;
    ei_nxt        = ei_r;
    a_nxt         = a_r;
    acc_nxt       = acc_r;
    drv_nxt       = drv_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_drive_nxt = out_drive_r;
    out_kick_nxt  = out_kick_r;
    mul_op.a      = '0;
    mul_op.b      = '0;
    raddr         = last_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == OP_SAMPLE)) begin
          spd_nxt   = in_tdata[SPEED_W-1:0];
          k_nxt     = last_idx;
          eq_nxt    = 1'b0;
          state_nxt = mph_r ? ST_MPH_LO : ST_SCAN;
        end
      end
      ST_MPH_LO: begin
        mul_op.a  = MUL_A_W'(spd_r[FRAC_W-1:0]);
        mul_op.b  = MPH_RATIO;
        state_nxt = ST_MPH_HI;
      end
      ST_MPH_HI: begin
        mul_op.a  = MUL_A_W'(spd_r[SPEED_W-1:FRAC_W]);
        mul_op.b  = MPH_RATIO;
        acc_nxt   = prod_x;
        state_nxt = ST_MPH_SUM;
      end
      ST_MPH_SUM: begin
        spd_nxt   = prod[SPEED_W-1:0] + SPEED_W'(acc_r[SPEED_W-1:FRAC_W]);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sint >= FRAC_W'(point)) begin
          eq_nxt    = (sint == FRAC_W'(point));
          state_nxt = ST_RD_I;
        end else if (k_r == IDX_W'(1)) begin
          drv_nxt   = lowd_r;
          state_nxt = ST_RD_LAST;
        end else begin
          k_nxt = k_r - IDX_W'(1);
        end
      end
      ST_RD_I: begin
        raddr     = idx_i;
        state_nxt = ST_RD_IM1;
      end
      ST_RD_IM1: begin
        raddr  = idx_i - IDX_W'(1);
        ei_nxt = rdata;
        if (eq_r) begin
          drv_nxt   = rdata;
          state_nxt = ST_RD_LAST;
        end else begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        mul_op.a  = MUL_A_W'(diff);
        mul_op.b  = TENTH_FP;
        state_nxt = ST_A_LATCH;
      end
      ST_A_LATCH: begin
        a_nxt     = prod[MUL_A_W-1:0];
        state_nxt = ST_B_MUL;
      end
      ST_B_MUL: begin
        mul_op.a  = a_r;
        mul_op.b  = MUL_B_W'(point);
        state_nxt = ST_B_SUB;
      end
      ST_B_SUB: begin
        mul_op.a  = a_r;
        mul_op.b  = spd_r[FRAC_W-1:0];
        acc_nxt   = $signed(ACC_W'({ei_r, {FRAC_W{1'b0}}})) - prod_x;
        state_nxt = ST_S_LO;
      end
      ST_S_LO: begin
        mul_op.a  = a_r;
        mul_op.b  = spd_r[SPEED_W-1:FRAC_W];
        acc_nxt   = acc_r + (prod_x >>> FRAC_W);
        state_nxt = ST_S_HI;
      end
      ST_S_HI: begin
        acc_nxt   = acc_r + prod_x;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        drv_nxt   = clamped;
        state_nxt = ST_RD_LAST;
      end
      ST_RD_LAST: begin
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (!out_valid_r || out_tready) begin
          if (drv_r > maxd_r) begin
            out_drive_nxt = maxd_r;
          end else begin
            out_drive_nxt = drv_r;
          end
          if (out_drive_nxt < rdata) begin
            out_drive_nxt = lowd_r;
          end
          out_kick_nxt  = (last_r == '0);
          last_nxt      = out_drive_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    eq_r        <= eq_nxt;
    spd_r       <= spd_nxt;
    ei_r        <= ei_nxt;
    a_r         <= a_nxt;
    acc_r       <= acc_nxt;
    drv_r       <= drv_nxt;
    out_drive_r <= out_drive_nxt;
    out_kick_r  <= out_kick_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = 16'(out_drive_r);
  assign out_tuser  = out_kick_r;

  // The scan never tests the point below the lowest table step.
  a_scan_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (k_r != '0))
    else $error("scan index reached zero");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_SAMPLE)) |=> (state_r != ST_IDLE))
    else $error("accepted sample did not start the sequencer");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_op == OP_TABLE_WR)) |=> (state_r == ST_IDLE))
    else $error("table write left the idle state");

  a_result_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_CLAMP))
    else $error("result appeared outside the final step");

endmodule
`default_nettype wire

>>> hw/rtl/sdi_table.sv
// Calibration table memory with one write port and one registered read port.
`default_nettype none
module sdi_table
  import sdi_pkg::*;
(
  input  wire logic               clk,
  input  wire sdi_tbl_wr_t        wr,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic      [DRIVE_W-1:0] rdata
);

  logic [DRIVE_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/sdi_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
`default_nettype none
module sdi_mul
  import sdi_pkg::*;
(
  input  wire logic               clk,
  input  wire sdi_mul_op_t        op,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_c;

  assign prod_c = PROD_W'(op.a) * $signed({1'b0, op.b});

  always_ff @(posedge clk) begin
    prod <= prod_c;
  end

endmodule
`default_nettype wire
